### hw/rtl/two_class_task_dispatcher_core_assert.svh
// Assertion macros for the task dispatcher core.
// Included by the top level; expects a signal named clock and one named reset.
`ifndef TWO_CLASS_TASK_DISPATCHER_CORE_ASSERT_SVH
`define TWO_CLASS_TASK_DISPATCHER_CORE_ASSERT_SVH

// Check a property on every rising edge, quiet while reset is high
`define DSP_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check an implication with the non-overlapping operator |=>
`define DSP_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) pre |=> post) else $error(msg);

`endif

### hw/rtl/dsp_pkg.sv
// Shared types, constants and helpers for the task dispatcher core.
// No dependencies; used by the core.
package dsp_pkg;

   // default table depths
   localparam int RT_ENTRIES_DEF   = 64;
   localparam int FAIR_ENTRIES_DEF = 64;

   // input kinds
   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // result classes
   localparam logic CLASS_RT   = 1'b0;
   localparam logic CLASS_FAIR = 1'b1;

   // priority bands
   localparam logic [7:0] RT_PRIO_MAX = 8'd99;
   localparam logic [7:0] BAND_110    = 8'd110;
   localparam logic [7:0] BAND_120    = 8'd120;
   localparam logic [7:0] BAND_130    = 8'd130;
   localparam logic [7:0] BAND_140    = 8'd140;

   // register indexes
   localparam logic [2:0] CSR_RT_QUANTUM = 3'd0;
   localparam logic [2:0] CSR_WEIGHT_100 = 3'd1;
   localparam logic [2:0] CSR_WEIGHT_110 = 3'd2;
   localparam logic [2:0] CSR_WEIGHT_120 = 3'd3;
   localparam logic [2:0] CSR_WEIGHT_130 = 3'd4;

   // register reset values
   localparam logic [3:0] QUANTUM_RST    = 4'd2;
   localparam logic [7:0] WEIGHT_100_RST = 8'd12;
   localparam logic [7:0] WEIGHT_110_RST = 8'd15;
   localparam logic [7:0] WEIGHT_120_RST = 8'd20;
   localparam logic [7:0] WEIGHT_130_RST = 8'd30;

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_ADD       = 7'b0000010,
      ST_RT_SCAN   = 7'b0000100,
      ST_RT_PICK   = 7'b0001000,
      ST_FAIR_SCAN = 7'b0010000,
      ST_FAIR_PICK = 7'b0100000,
      ST_DONE      = 7'b1000000
   } state_type;

   // real-time table entry
   typedef struct packed {
      logic [6:0]  prio;
      logic [15:0] id;
      logic [15:0] remaining;
      logic [15:0] stamp;
   } rt_entry_type;

   // fair table entry
   typedef struct packed {
      logic [7:0]  prio;
      logic [23:0] vruntime;
      logic [16:0] runs;
      logic [15:0] remaining;
   } fair_entry_type;

   // true when a should run before b
   function automatic logic fair_better(fair_entry_type a, fair_entry_type b);
      logic res;
      if (a.vruntime != b.vruntime) begin
         res = a.vruntime < b.vruntime;
      end else if (a.runs != b.runs) begin
         res = a.runs < b.runs;
      end else if (a.prio != b.prio) begin
         res = a.prio < b.prio;
      end else begin
         res = a.remaining > b.remaining;
      end
      return res;
   endfunction

endpackage

### hw/rtl/dsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/two_class_task_dispatcher_core.sv
// Two-class task dispatcher: a real-time round robin table and a fair table.
// Depends on dsp_pkg, dsp_ram and two_class_task_dispatcher_core_assert.svh.
//
// Usage:
//   req_* carries one beat: an add (kind 0) or a tick (kind 1). A beat is taken
//   when req_valid is high and req_stall low; req_stall is high while an
//   earlier beat is still being worked on, and a new beat is taken as soon as
//   the engine is back in idle.
//   An add walks the valid bits of its table for the lowest free entry; adds
//   to a full table are dropped. A tick reads the real-time RAM once per entry;
//   if no real-time task is present it also walks the fair RAM; the done
//   state then loads the output register once it is free.
//   Each tick yields one rsp_* beat; adds yield none. The output register lets
//   a new beat in while a result waits; if rsp_stall is still high when the
//   next result is ready, the engine holds it until the register drains.
//   csr_* writes a register; write only while the block is idle (not enforced).
//   Reset (synchronous) empties both tables through their valid bits, clears
//   the stamp counter and turn state and loads register defaults.
module two_class_task_dispatcher_core #(
   parameter int RT_ENTRIES   = dsp_pkg::RT_ENTRIES_DEF,
   parameter int FAIR_ENTRIES = dsp_pkg::FAIR_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request beat
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_priority_req,
   input  logic [15:0] req_task_id,
   input  logic [15:0] req_run_count,
   // result beat
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_slot_valid,
   output logic        rsp_task_class,
   output logic [7:0]  rsp_slot_priority,
   output logic [15:0] rsp_slot_task,
   output logic        rsp_level_done,
   // register writes
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   `include "two_class_task_dispatcher_core_assert.svh"

   localparam int RIW = (RT_ENTRIES > 1) ? $clog2(RT_ENTRIES) : 1;
   localparam int FIW = (FAIR_ENTRIES > 1) ? $clog2(FAIR_ENTRIES) : 1;
   localparam int RCW = $clog2(RT_ENTRIES + 1);
   localparam int FCW = $clog2(FAIR_ENTRIES + 1);
   localparam int RTW = $bits(dsp_pkg::rt_entry_type);
   localparam int FTW = $bits(dsp_pkg::fair_entry_type);

   // control state
   dsp_pkg::state_type state_ff, state_in;
   logic [RT_ENTRIES-1:0]   rt_valid_ff, rt_valid_in;
   logic [FAIR_ENTRIES-1:0] fair_valid_ff, fair_valid_in;
   logic [15:0]  arr_ff, arr_in;
   logic         rt_active_ff, rt_active_in;
   logic [RIW-1:0] cur_ff, cur_in;
   logic [3:0]   qused_ff, qused_in;
   logic [RCW-1:0] rsc_ff, rsc_in;
   logic [FCW-1:0] fsc_ff, fsc_in;
   logic         pv_ff, pv_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [3:0]   quantum_ff, quantum_in;
   logic [7:0]   w100_ff, w100_in, w110_ff, w110_in, w120_ff, w120_in, w130_ff, w130_in;

   // payload state
   logic [7:0]   a_prio_ff, a_prio_in;
   logic [15:0]  a_id_ff, a_id_in;
   logic [15:0]  a_cnt_ff, a_cnt_in;
   logic [RIW-1:0] rpidx_ff, rpidx_in;
   logic [FIW-1:0] fpidx_ff, fpidx_in;
   logic [6:0]   minp_ff, minp_in;
   logic [RCW-1:0] cnt_ff, cnt_in;
   logic [RIW-1:0] best_ff, best_in;
   dsp_pkg::rt_entry_type bent_ff, bent_in, cent_ff, cent_in;
   logic [15:0]  bage_ff, bage_in;
   logic         cur_hit_ff, cur_hit_in;
   logic         ffound_ff, ffound_in;
   logic [FIW-1:0] fbest_ff, fbest_in;
   dsp_pkg::fair_entry_type fbent_ff, fbent_in;
   logic         r_valid_ff, r_valid_in, r_class_ff, r_class_in, r_done_ff, r_done_in;
   logic [7:0]   r_prio_ff, r_prio_in;
   logic [15:0]  r_task_ff, r_task_in;
   logic         o_valid_ff, o_valid_in, o_class_ff, o_class_in, o_done_ff, o_done_in;
   logic [7:0]   o_prio_ff, o_prio_in;
   logic [15:0]  o_task_ff, o_task_in;

   // memory ports
   logic           rt_we, fair_we;
   logic [RIW-1:0] rt_waddr, rt_raddr;
   logic [FIW-1:0] fair_waddr, fair_raddr;
   dsp_pkg::rt_entry_type   rt_wdata, rt_rdata;
   dsp_pkg::fair_entry_type fair_wdata, fair_rdata;
   logic [RTW-1:0] rt_rd_bits;
   logic [FTW-1:0] fair_rd_bits;

   assign rt_rdata   = dsp_pkg::rt_entry_type'(rt_rd_bits);
   assign fair_rdata = dsp_pkg::fair_entry_type'(fair_rd_bits);

   dsp_ram #(.WIDTH(RTW), .DEPTH(RT_ENTRIES)) u_rt_ram (
      .clock   (clock),
      .wr_en   (rt_we),
      .wr_addr (rt_waddr),
      .wr_data (RTW'(rt_wdata)),
      .rd_addr (rt_raddr),
      .rd_data (rt_rd_bits)
   );

   dsp_ram #(.WIDTH(FTW), .DEPTH(FAIR_ENTRIES)) u_fair_ram (
      .clock   (clock),
      .wr_en   (fair_we),
      .wr_addr (fair_waddr),
      .wr_data (FTW'(fair_wdata)),
      .rd_addr (fair_raddr),
      .rd_data (fair_rd_bits)
   );

   assign req_stall = (state_ff != dsp_pkg::ST_IDLE);

   // register writes
   always_comb begin
      quantum_in = quantum_ff;
      w100_in    = w100_ff;
      w110_in    = w110_ff;
      w120_in    = w120_ff;
      w130_in    = w130_ff;
      if (csr_write) begin
         case (csr_index)
            dsp_pkg::CSR_RT_QUANTUM: quantum_in = csr_wdata[3:0];
            dsp_pkg::CSR_WEIGHT_100: w100_in    = csr_wdata;
            dsp_pkg::CSR_WEIGHT_110: w110_in    = csr_wdata;
            dsp_pkg::CSR_WEIGHT_120: w120_in    = csr_wdata;
            dsp_pkg::CSR_WEIGHT_130: w130_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer: add search, table scans, pick and write-back
   always_comb begin
      logic [15:0] age;
      logic        keep;
      dsp_pkg::rt_entry_type   sel, upd;
      dsp_pkg::fair_entry_type fupd;
      logic [RIW-1:0] sidx;
      logic [3:0]  qbase, qeff, qu;
      logic [7:0]  w;
      logic        out_free;

      state_in      = state_ff;
      rt_valid_in   = rt_valid_ff;
      fair_valid_in = fair_valid_ff;
      arr_in        = arr_ff;
      rt_active_in  = rt_active_ff;
      cur_in        = cur_ff;
      qused_in      = qused_ff;
      rsc_in        = rsc_ff;
      fsc_in        = fsc_ff;
      pv_in         = 1'b0;
      a_prio_in     = a_prio_ff;
      a_id_in       = a_id_ff;
      a_cnt_in      = a_cnt_ff;
      rpidx_in      = rpidx_ff;
      fpidx_in      = fpidx_ff;
      minp_in       = minp_ff;
      cnt_in        = cnt_ff;
      best_in       = best_ff;
      bent_in       = bent_ff;
      cent_in       = cent_ff;
      bage_in       = bage_ff;
      cur_hit_in    = cur_hit_ff;
      ffound_in     = ffound_ff;
      fbest_in      = fbest_ff;
      fbent_in      = fbent_ff;
      r_valid_in    = r_valid_ff;
      r_class_in    = r_class_ff;
      r_prio_in     = r_prio_ff;
      r_task_in     = r_task_ff;
      r_done_in     = r_done_ff;
      o_valid_in    = o_valid_ff;
      o_class_in    = o_class_ff;
      o_prio_in     = o_prio_ff;
      o_task_in     = o_task_ff;
      o_done_in     = o_done_ff;
      rt_we         = 1'b0;
      rt_waddr      = rsc_ff[RIW-1:0];
      rt_wdata      = '0;
      rt_raddr      = rsc_ff[RIW-1:0];
      fair_we       = 1'b0;
      fair_waddr    = fsc_ff[FIW-1:0];
      fair_wdata    = '0;
      fair_raddr    = fsc_ff[FIW-1:0];
      age           = arr_ff - rt_rdata.stamp;
      keep          = 1'b0;
      sel           = bent_ff;
      upd           = bent_ff;
      fupd          = fbent_ff;
      sidx          = best_ff;
      qbase         = 4'd0;
      qeff          = (quantum_ff == 4'd0) ? 4'd1 : quantum_ff;
      qu            = 4'd0;
      w             = 8'd0;
      out_free      = !rsp_valid_ff || !rsp_stall;

      // drain the output register
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         dsp_pkg::ST_IDLE: begin
            if (req_valid) begin
               rsc_in = '0;
               fsc_in = '0;
               if (req_kind == dsp_pkg::KIND_ADD) begin
                  a_prio_in = req_priority_req;
                  a_id_in   = req_task_id;
                  a_cnt_in  = (req_run_count == 16'd0) ? 16'd1 : req_run_count;
                  state_in  = dsp_pkg::ST_ADD;
               end else begin
                  cnt_in     = '0;
                  cur_hit_in = 1'b0;
                  ffound_in  = 1'b0;
                  state_in   = dsp_pkg::ST_RT_SCAN;
               end
            end
         end

         // walk valid bits for the lowest free entry
         dsp_pkg::ST_ADD: begin
            if (a_prio_ff <= dsp_pkg::RT_PRIO_MAX) begin
               if (rsc_ff == RCW'(RT_ENTRIES)) begin
                  state_in = dsp_pkg::ST_IDLE;
               end else if (!rt_valid_ff[rsc_ff[RIW-1:0]]) begin
                  rt_we          = 1'b1;
                  rt_wdata.prio  = a_prio_ff[6:0];
                  rt_wdata.id    = a_id_ff;
                  rt_wdata.remaining = a_cnt_ff;
                  rt_wdata.stamp = arr_ff;
                  arr_in         = arr_ff + 16'd1;
                  rt_valid_in[rsc_ff[RIW-1:0]] = 1'b1;
                  state_in       = dsp_pkg::ST_IDLE;
               end else begin
                  rsc_in = rsc_ff + RCW'(1);
               end
            end else begin
               if (fsc_ff == FCW'(FAIR_ENTRIES)) begin
                  state_in = dsp_pkg::ST_IDLE;
               end else if (!fair_valid_ff[fsc_ff[FIW-1:0]]) begin
                  fair_we            = 1'b1;
                  fair_wdata.prio    = a_prio_ff;
                  fair_wdata.vruntime = '0;
                  fair_wdata.runs    = '0;
                  fair_wdata.remaining = a_cnt_ff;
                  fair_valid_in[fsc_ff[FIW-1:0]] = 1'b1;
                  state_in           = dsp_pkg::ST_IDLE;
               end else begin
                  fsc_in = fsc_ff + FCW'(1);
               end
            end
         end

         // one read per cycle; fold the returning word into the running best
         dsp_pkg::ST_RT_SCAN: begin
            if (rsc_ff != RCW'(RT_ENTRIES)) begin
               pv_in    = 1'b1;
               rpidx_in = rsc_ff[RIW-1:0];
               rsc_in   = rsc_ff + RCW'(1);
            end
            if (pv_ff && rt_valid_ff[rpidx_ff]) begin
               if (cnt_ff == '0 || rt_rdata.prio < minp_ff) begin
                  minp_in = rt_rdata.prio;
                  cnt_in  = RCW'(1);
                  best_in = rpidx_ff;
                  bent_in = rt_rdata;
                  bage_in = age;
               end else if (rt_rdata.prio == minp_ff) begin
                  cnt_in = cnt_ff + RCW'(1);
                  if (age > bage_ff) begin
                     best_in = rpidx_ff;
                     bent_in = rt_rdata;
                     bage_in = age;
                  end
               end
               if (rpidx_ff == cur_ff) begin
                  cur_hit_in = 1'b1;
                  cent_in    = rt_rdata;
               end
            end
            if (rsc_ff == RCW'(RT_ENTRIES) && !pv_ff) begin
               state_in = dsp_pkg::ST_RT_PICK;
            end
         end

         // continue the current turn or start a fresh one, then write back
         dsp_pkg::ST_RT_PICK: begin
            if (cnt_ff == '0) begin
               state_in = dsp_pkg::ST_FAIR_SCAN;
            end else begin
               keep  = rt_active_ff && cur_hit_ff && (cent_ff.prio == minp_ff);
               sel   = keep ? cent_ff : bent_ff;
               sidx  = keep ? cur_ff : best_ff;
               qbase = keep ? qused_ff : 4'd0;
               upd   = sel;
               r_valid_in = 1'b1;
               r_class_in = dsp_pkg::CLASS_RT;
               r_prio_in  = {1'b0, sel.prio};
               r_task_in  = sel.id;
               rt_waddr   = sidx;
               if (sel.remaining <= 16'd1) begin
                  rt_valid_in[sidx] = 1'b0;
                  rt_active_in      = 1'b0;
                  qused_in          = 4'd0;
                  r_done_in         = (cnt_ff == RCW'(1));
               end else begin
                  upd.remaining = sel.remaining - 16'd1;
                  qu            = qbase + 4'd1;
                  r_done_in     = 1'b0;
                  if (qu >= qeff) begin
                     upd.stamp    = arr_ff;
                     arr_in       = arr_ff + 16'd1;
                     rt_active_in = 1'b0;
                     qused_in     = 4'd0;
                  end else begin
                     rt_active_in = 1'b1;
                     cur_in       = sidx;
                     qused_in     = qu;
                  end
                  rt_we    = 1'b1;
                  rt_wdata = upd;
               end
               state_in = dsp_pkg::ST_DONE;
            end
         end

         dsp_pkg::ST_FAIR_SCAN: begin
            if (fsc_ff != FCW'(FAIR_ENTRIES)) begin
               pv_in    = 1'b1;
               fpidx_in = fsc_ff[FIW-1:0];
               fsc_in   = fsc_ff + FCW'(1);
            end
            if (pv_ff && fair_valid_ff[fpidx_ff]) begin
               if (!ffound_ff || dsp_pkg::fair_better(fair_rdata, fbent_ff)) begin
                  ffound_in = 1'b1;
                  fbest_in  = fpidx_ff;
                  fbent_in  = fair_rdata;
               end
            end
            if (fsc_ff == FCW'(FAIR_ENTRIES) && !pv_ff) begin
               state_in = dsp_pkg::ST_FAIR_PICK;
            end
         end

         // charge the band weight below band 140, then write back or retire the entry
         dsp_pkg::ST_FAIR_PICK: begin
            r_task_in = '0;
            r_done_in = 1'b0;
            if (!ffound_ff) begin
               r_valid_in = 1'b0;
               r_class_in = dsp_pkg::CLASS_RT;
               r_prio_in  = '0;
            end else begin
               r_valid_in = 1'b1;
               r_class_in = dsp_pkg::CLASS_FAIR;
               r_prio_in  = fbent_ff.prio;
               if (fbent_ff.prio < dsp_pkg::BAND_110) begin
                  w = w100_ff;
               end else if (fbent_ff.prio < dsp_pkg::BAND_120) begin
                  w = w110_ff;
               end else if (fbent_ff.prio < dsp_pkg::BAND_130) begin
                  w = w120_ff;
               end else begin
                  w = w130_ff;
               end
               fupd = fbent_ff;
               if (fbent_ff.prio < dsp_pkg::BAND_140) begin
                  fupd.vruntime = fbent_ff.vruntime + 24'(w);
                  fupd.runs     = fbent_ff.runs + 17'd1;
               end
               fair_waddr = fbest_ff;
               if (fbent_ff.remaining <= 16'd1) begin
                  fair_valid_in[fbest_ff] = 1'b0;
               end else begin
                  fupd.remaining = fbent_ff.remaining - 16'd1;
                  fair_we        = 1'b1;
                  fair_wdata     = fupd;
               end
            end
            state_in = dsp_pkg::ST_DONE;
         end

         // hand the result to the output register once it is free
         dsp_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_valid_in   = r_valid_ff;
               o_class_in   = r_class_ff;
               o_prio_in    = r_prio_ff;
               o_task_in    = r_task_ff;
               o_done_in    = r_done_ff;
               state_in     = dsp_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = dsp_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dsp_pkg::ST_IDLE;
         rt_valid_ff   <= '0;
         fair_valid_ff <= '0;
         arr_ff        <= '0;
         rt_active_ff  <= 1'b0;
         cur_ff        <= '0;
         qused_ff      <= '0;
         rsc_ff        <= '0;
         fsc_ff        <= '0;
         pv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         quantum_ff    <= dsp_pkg::QUANTUM_RST;
         w100_ff       <= dsp_pkg::WEIGHT_100_RST;
         w110_ff       <= dsp_pkg::WEIGHT_110_RST;
         w120_ff       <= dsp_pkg::WEIGHT_120_RST;
         w130_ff       <= dsp_pkg::WEIGHT_130_RST;
      end else begin
         state_ff      <= state_in;
         rt_valid_ff   <= rt_valid_in;
         fair_valid_ff <= fair_valid_in;
         arr_ff        <= arr_in;
         rt_active_ff  <= rt_active_in;
         cur_ff        <= cur_in;
         qused_ff      <= qused_in;
         rsc_ff        <= rsc_in;
         fsc_ff        <= fsc_in;
         pv_ff         <= pv_in;
         rsp_valid_ff  <= rsp_valid_in;
         quantum_ff    <= quantum_in;
         w100_ff       <= w100_in;
         w110_ff       <= w110_in;
         w120_ff       <= w120_in;
         w130_ff       <= w130_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_prio_ff  <= a_prio_in;
      a_id_ff    <= a_id_in;
      a_cnt_ff   <= a_cnt_in;
      rpidx_ff   <= rpidx_in;
      fpidx_ff   <= fpidx_in;
      minp_ff    <= minp_in;
      cnt_ff     <= cnt_in;
      best_ff    <= best_in;
      bent_ff    <= bent_in;
      cent_ff    <= cent_in;
      bage_ff    <= bage_in;
      cur_hit_ff <= cur_hit_in;
      ffound_ff  <= ffound_in;
      fbest_ff   <= fbest_in;
      fbent_ff   <= fbent_in;
      r_valid_ff <= r_valid_in;
      r_class_ff <= r_class_in;
      r_prio_ff  <= r_prio_in;
      r_task_ff  <= r_task_in;
      r_done_ff  <= r_done_in;
      o_valid_ff <= o_valid_in;
      o_class_ff <= o_class_in;
      o_prio_ff  <= o_prio_in;
      o_task_ff  <= o_task_in;
      o_done_ff  <= o_done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot_valid    = o_valid_ff;
   assign rsp_task_class    = o_class_ff;
   assign rsp_slot_priority = o_prio_ff;
   assign rsp_slot_task     = o_task_ff;
   assign rsp_level_done    = o_done_ff;

   // a finished tick reaches an empty output register on the next edge
   `DSP_ASSERT_NEXT(a_done_moves, (state_ff == dsp_pkg::ST_DONE) && !rsp_valid_ff, rsp_valid_ff, "finished tick did not reach the output")
   // an idle slot carries all-zero fields
   `DSP_ASSERT(a_idle_zero, (rsp_valid_ff && !o_valid_ff) |-> (!o_class_ff && o_prio_ff == 8'd0 && o_task_ff == 16'd0 && !o_done_ff), "idle slot with non-zero fields")
   // a fair dispatch reports no task and no level flag
   `DSP_ASSERT(a_fair_fields, (rsp_valid_ff && o_class_ff) |-> (o_valid_ff && o_task_ff == 16'd0 && !o_done_ff), "fair slot with task or level flag")

endmodule
